// ===== sv/gsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gsp_pkg;
   localparam int unsigned IDX_W = 10;
   localparam int unsigned GEN_W = 15;
   localparam int unsigned REF_W = 16;
   localparam int unsigned CNT_W = 11;

   typedef enum logic [2:0] {
      ACT_ALLOC   = 3'd0,
      ACT_ADDREF  = 3'd1,
      ACT_RELEASE = 3'd2,
      ACT_LOOKUP  = 3'd3,
      ACT_COLLECT = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]       action;
      logic [IDX_W-1:0] slot_index;
      logic [GEN_W-1:0] handle_gen;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] out_index;
      logic [GEN_W-1:0] out_gen;
      logic [REF_W-1:0] ref_count;
      logic [CNT_W-1:0] freed_count;
      logic [CNT_W-1:0] live_count;
   } rsp_type;
endpackage
`default_nettype wire

// ===== sv/gsp_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gsp_req_if;
   import gsp_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/gsp_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gsp_rsp_if;
   import gsp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/generational_slot_pool.sv =====
// Channel   Dir  Payload
// req_chan  in   action, slot_index, handle_gen
// rsp_chan  out  status, out_index, out_gen, ref_count, freed_count, live_count
//
// Handle operations read slot memory, then modify and write back the slot.
// Collect reads one slot per cycle below high_water; writes trail via sw_v/sw_a.
// Reset clears each slot word (in_use, generation, refs) in one pass; req is
// held off until it ends. A waiting result stalls only the next request.
`timescale 1ns / 1ps
`default_nettype none
module generational_slot_pool #(
   parameter int unsigned SLOTS = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   gsp_req_if.sink   req_chan,
   gsp_rsp_if.source rsp_chan
);
   import gsp_pkg::*;

   localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW = $clog2(SLOTS + 1);
   localparam logic [REF_W-1:0] REF_MAX = '1;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_OP    = 5'b00100,
      S_SWEEP = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   // slot word: in_use, generation, refs
   localparam int unsigned SW = 1 + GEN_W + REF_W;
   logic [SW-1:0]    slot_mem [SLOTS];
   logic [AW-1:0]    fifo_mem [SLOTS];

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]    fill_ff, fill_in, hw_ff, hw_in, live_ff, live_in, freed_ff, freed_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [AW-1:0]    alloc_ff, alloc_in;
   logic             sw_v_ff, sw_v_in;
   logic [AW-1:0]    sw_a_ff, sw_a_in;

   logic [SW-1:0]    rd_ff;
   logic [AW-1:0]    fifo_rd_ff;
   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [SW-1:0]    wr_data;
   logic             fwr_en;

   logic             r_use;
   logic [GEN_W-1:0] r_gen, g_next;
   logic [REF_W-1:0] r_ref, n_ref;

   assign r_use = rd_ff[SW-1];
   assign r_gen = rd_ff[SW-2 -: GEN_W];
   assign r_ref = rd_ff[REF_W-1:0];
   assign g_next = r_gen + GEN_W'(1);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= slot_mem[rd_addr];
      end
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      fifo_rd_ff <= fifo_mem[head_ff];
      if (fwr_en) begin
         fifo_mem[tail_ff] <= sw_a_ff;
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      hw_in = hw_ff;
      live_in = live_ff;
      freed_in = freed_ff;
      ptr_in = ptr_ff;
      alloc_in = alloc_ff;
      sw_v_in = 1'b0;
      sw_a_in = sw_a_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      fwr_en = 1'b0;
      n_ref = r_ref;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            ptr_in = ptr_ff + CW'(1);
            if (ptr_ff == CW'(SLOTS - 1)) begin
               state_in = S_IDLE;
               ptr_in = '0;
            end
         end
         S_IDLE: begin
            if (req_chan.valid && req_chan.ready) begin
               req_in = req_chan.payload;
               rsp_in = '0;
               rsp_in.live_count = CNT_W'(live_ff);
               state_in = S_OUT;
               case (req_chan.payload.action)
                  ACT_ALLOC: begin
                     if (fill_ff != '0) begin
                        alloc_in = fifo_rd_ff;
                        head_in = (head_ff == AW'(SLOTS - 1)) ? '0 : head_ff + AW'(1);
                        fill_in = fill_ff - CW'(1);
                        rd_en = 1'b1;
                        rd_addr = fifo_rd_ff;
                        state_in = S_OP;
                     end else if (hw_ff < CW'(SLOTS)) begin
                        alloc_in = hw_ff[AW-1:0];
                        hw_in = hw_ff + CW'(1);
                        rd_en = 1'b1;
                        rd_addr = hw_ff[AW-1:0];
                        state_in = S_OP;
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                  end
                  ACT_ADDREF, ACT_RELEASE, ACT_LOOKUP: begin
                     if (req_chan.payload.handle_gen == '0 ||
                         {1'b0, req_chan.payload.slot_index} >= (IDX_W+1)'(hw_ff) ||
                         {1'b0, req_chan.payload.slot_index} >= (IDX_W+1)'(SLOTS)) begin
                        rsp_in.status = ST_INVALID;
                     end else begin
                        alloc_in = AW'(req_chan.payload.slot_index);
                        rd_en = 1'b1;
                        rd_addr = AW'(req_chan.payload.slot_index);
                        state_in = S_OP;
                     end
                  end
                  ACT_COLLECT: begin
                     freed_in = '0;
                     ptr_in = '0;
                     state_in = S_SWEEP;
                  end
                  default: rsp_in.status = ST_INVALID;
               endcase
               if (state_in == S_OUT) begin
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_OP: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            if (req_ff.action == ACT_ALLOC) begin
               wr_en = 1'b1;
               wr_addr = alloc_ff;
               wr_data = {1'b1, (g_next == '0) ? GEN_W'(1) : g_next, REF_W'(1)};
               if (!r_use) begin
                  live_in = live_ff + CW'(1);
               end
               rsp_in.out_index = IDX_W'(alloc_ff);
               rsp_in.out_gen = (g_next == '0) ? GEN_W'(1) : g_next;
               rsp_in.ref_count = REF_W'(1);
               rsp_in.live_count = CNT_W'(r_use ? live_ff : live_ff + CW'(1));
            end else if (r_use && r_gen == req_ff.handle_gen) begin
               if (req_ff.action == ACT_ADDREF && r_ref != REF_MAX) begin
                  n_ref = r_ref + REF_W'(1);
               end else if (req_ff.action == ACT_RELEASE && r_ref != '0) begin
                  n_ref = r_ref - REF_W'(1);
               end
               wr_en = 1'b1;
               wr_addr = alloc_ff;
               wr_data = {1'b1, r_gen, n_ref};
               rsp_in.out_index = req_ff.slot_index;
               rsp_in.out_gen = r_gen;
               rsp_in.ref_count = n_ref;
            end else begin
               rsp_in.status = ST_INVALID;
            end
         end
         S_SWEEP: begin
            if (sw_v_ff) begin
               if (r_use && r_ref == '0) begin
                  wr_en = 1'b1;
                  wr_addr = sw_a_ff;
                  wr_data = {1'b0, g_next, r_ref};
                  freed_in = freed_ff + CW'(1);
                  if (fill_ff < CW'(SLOTS)) begin
                     fwr_en = 1'b1;
                     tail_in = (tail_ff == AW'(SLOTS - 1)) ? '0 : tail_ff + AW'(1);
                     fill_in = fill_ff + CW'(1);
                  end
               end
            end
            if (ptr_ff < hw_ff) begin
               rd_en = 1'b1;
               rd_addr = ptr_ff[AW-1:0];
               sw_v_in = 1'b1;
               sw_a_in = ptr_ff[AW-1:0];
               ptr_in = ptr_ff + CW'(1);
            end else if (!sw_v_ff) begin
               live_in = (live_ff >= freed_ff) ? live_ff - freed_ff : '0;
               rsp_in = '0;
               rsp_in.freed_count = CNT_W'(freed_ff);
               rsp_in.live_count = (live_ff >= freed_ff) ? CNT_W'(live_ff - freed_ff) : '0;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
         hw_ff <= '0;
         live_ff <= '0;
         freed_ff <= '0;
         ptr_ff <= '0;
         sw_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         hw_ff <= hw_in;
         live_ff <= live_in;
         freed_ff <= freed_in;
         ptr_ff <= ptr_in;
         sw_v_ff <= sw_v_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      alloc_ff <= alloc_in;
      sw_a_ff <= sw_a_in;
   end
endmodule
`default_nettype wire
